FILE: hw/rtl/trrl_pkg.sv
// Package for the token ring range lookup block.
// Holds operation and status codes, the key order constant and the token
// type that walks the cell chain. No dependencies.
package trrl_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_CLEAR  = 2'd2
   } trrl_op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } trrl_status_type;

   // Flipping the sign bit maps two's complement order onto unsigned order.
   localparam logic [63:0] KEY_FLIP = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic        valid;
      logic [1:0]  operation;
      logic [63:0] key;
      logic [31:0] address;
      logic        matched;
      logic        have_below;
      logic [63:0] below_key;
      logic [31:0] below_address;
      logic        have_max;
      logic [63:0] max_key;
      logic [31:0] max_address;
   } trrl_token_type;

endpackage

FILE: hw/rtl/trrl_chan_if.sv
// Handshake channel interfaces for requests and responses.
// Depends on nothing but the widths of the item fields.
interface trrl_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic signed [63:0] token;
   logic [31:0]        node_address;

   modport source (output valid, output operation, output token, output node_address,
                   input ready);
   modport sink   (input valid, input operation, input token, input node_address,
                   output ready);
endinterface

interface trrl_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] found_address;
   logic [1:0]  status;

   modport source (output valid, output found_address, output status, input ready);
   modport sink   (input valid, input found_address, input status, output ready);
endinterface

FILE: hw/rtl/trrl_cell.sv
// One cell of the range table: a stored entry and a token stage.
// Depends on trrl_pkg for the token type and operation codes.
module trrl_cell #(
   parameter int CELL_INDEX  = 0,
   parameter int COUNT_WIDTH = 7
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [COUNT_WIDTH-1:0]  entry_count,
   input  trrl_pkg::trrl_token_type token_in,
   output trrl_pkg::trrl_token_type token_out
);
   import trrl_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] MY_INDEX = COUNT_WIDTH'(CELL_INDEX);

   logic [63:0]    start_ff, start_in;
   logic [31:0]    address_ff, address_in;
   logic           write_en;
   logic           entry_valid;
   logic           is_tail;
   trrl_token_type token_out_ff, token_out_in;

   assign entry_valid = MY_INDEX < entry_count;
   assign is_tail     = MY_INDEX == entry_count;

   always_comb begin
      token_out_in = token_in;
      write_en     = 1'b0;
      start_in     = start_ff;
      address_in   = address_ff;
      if (token_in.valid) begin
         case (token_in.operation)
            OP_INSERT: begin
               if (entry_valid && !token_in.matched && start_ff == token_in.key) begin
                  write_en             = 1'b1;
                  address_in           = token_in.address;
                  token_out_in.matched = 1'b1;
               end else if (is_tail && !token_in.matched) begin
                  // Every valid cell lies upstream, so the key is new here.
                  write_en   = 1'b1;
                  start_in   = token_in.key;
                  address_in = token_in.address;
               end
            end
            OP_LOOKUP: begin
               if (entry_valid) begin
                  if (!token_in.have_max || start_ff > token_in.max_key) begin
                     token_out_in.have_max    = 1'b1;
                     token_out_in.max_key     = start_ff;
                     token_out_in.max_address = address_ff;
                  end
                  if (start_ff <= token_in.key &&
                      (!token_in.have_below || start_ff > token_in.below_key)) begin
                     token_out_in.have_below    = 1'b1;
                     token_out_in.below_key     = start_ff;
                     token_out_in.below_address = address_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (advance && write_en) begin
         start_ff   <= start_in;
         address_ff <= address_in;
      end
      if (reset) begin
         token_out_ff.valid <= 1'b0;
      end else if (advance) begin
         token_out_ff <= token_out_in;
      end
   end

   assign token_out = token_out_ff;

endmodule

FILE: hw/rtl/token_ring_range_lookup_unit.sv
// Top level of the token ring range lookup block: entry stage, cell chain,
// entry count and response register. Depends on trrl_pkg, trrl_chan_if, trrl_cell.
//
//   channel   direction   handshake             payload
//   req_chan  in          valid / ready         operation, token, node_address
//   rsp_chan  out         valid / ready         found_address, status
//
// An item walks the chain one cell per clock while the chain is not frozen; its
// result is registered in the response register after it leaves the last cell,
// and the next item is accepted only once the last one has left the chain.
// Synchronous reset empties the table and drops any item in flight.
// A result still waiting when the next item reaches the last cell freezes the
// chain; the next item is accepted while a finished result waits in the register.
module token_ring_range_lookup_unit #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic          clock,
   input  logic          reset,
   trrl_req_if.sink      req_chan,
   trrl_rsp_if.source    rsp_chan
);
   import trrl_pkg::*;

   localparam int COUNT_WIDTH = $clog2(TABLE_ENTRIES + 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(TABLE_ENTRIES);

   trrl_token_type            chain [0:TABLE_ENTRIES];
   logic [TABLE_ENTRIES:0]    chain_valid;
   trrl_token_type            head_ff, head_in;
   trrl_token_type            tail_token;
   logic                      busy_ff, busy_in;
   logic [COUNT_WIDTH-1:0]    entry_count_ff, entry_count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [31:0]               rsp_address_ff, rsp_address_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;
   logic                      req_accept;
   logic                      advance;
   logic                      finish;
   trrl_status_type           fin_status;
   logic [31:0]               fin_address;

   assign req_chan.ready = !busy_ff && !reset;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign tail_token = chain[TABLE_ENTRIES];
   assign advance    = !(tail_token.valid && rsp_valid_ff && !rsp_chan.ready);
   assign finish     = tail_token.valid && advance;

   assign chain[0] = head_ff;

   genvar gi;
   generate
      for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
         trrl_cell #(
            .CELL_INDEX  (gi),
            .COUNT_WIDTH (COUNT_WIDTH)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .advance     (advance),
            .entry_count (entry_count_ff),
            .token_in    (chain[gi]),
            .token_out   (chain[gi+1])
         );
      end
      for (gi = 0; gi <= TABLE_ENTRIES; gi++) begin : g_valid
         assign chain_valid[gi] = chain[gi].valid;
      end
   endgenerate

   always_comb begin
      head_in           = '0;
      head_in.valid     = 1'b1;
      head_in.operation = req_chan.operation;
      head_in.key       = 64'(req_chan.token) ^ KEY_FLIP;
      head_in.address   = req_chan.node_address;
   end

   // Result of the item leaving the last cell.
   always_comb begin
      fin_status  = ST_OK;
      fin_address = '0;
      case (tail_token.operation)
         OP_INSERT: begin
            if (!tail_token.matched && entry_count_ff == FULL_COUNT) begin
               fin_status = ST_FULL;
            end
         end
         OP_LOOKUP: begin
            if (entry_count_ff == '0) begin
               fin_status = ST_EMPTY;
            end else if (tail_token.have_below) begin
               fin_address = tail_token.below_address;
            end else begin
               fin_address = tail_token.max_address;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      busy_in        = busy_ff;
      entry_count_in = entry_count_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_address_in = rsp_address_ff;
      rsp_status_in  = rsp_status_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         busy_in        = 1'b0;
         rsp_valid_in   = 1'b1;
         rsp_address_in = fin_address;
         rsp_status_in  = fin_status;
         case (tail_token.operation)
            OP_INSERT: begin
               if (!tail_token.matched && entry_count_ff != FULL_COUNT) begin
                  entry_count_in = entry_count_ff + 1'b1;
               end
            end
            OP_CLEAR: begin
               entry_count_in = '0;
            end
            default: begin
            end
         endcase
      end
      if (req_accept) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (req_accept) begin
         head_ff <= head_in;
      end else if (advance) begin
         head_ff.valid <= 1'b0;
      end
      rsp_address_ff <= rsp_address_in;
      rsp_status_ff  <= rsp_status_in;
      if (reset) begin
         busy_ff        <= 1'b0;
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.found_address = rsp_address_ff;
   assign rsp_chan.status        = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= FULL_COUNT)
      else $error("entry count above table size");

   a_single_item: assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_valid))
      else $error("more than one item in the cell chain");

   a_tail_busy: assert property (@(posedge clock) disable iff (reset)
      tail_token.valid |-> busy_ff)
      else $error("item in chain while block is idle");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      finish && tail_token.operation == OP_CLEAR |=> entry_count_ff == '0)
      else $error("clear item left entries behind");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      finish && tail_token.operation == OP_INSERT && !tail_token.matched &&
      entry_count_ff != FULL_COUNT
      |=> entry_count_ff == COUNT_WIDTH'($past(entry_count_ff) + 1'b1))
      else $error("new entry not counted");
`endif

endmodule

FILE: tb/token_ring_range_lookup_unit_checker.sv
// Checker for the token ring range lookup block: watches both channels,
// predicts each result from its own copy of the range table and compares.
// Depends on trrl_pkg and the channel interfaces in trrl_chan_if.
`timescale 1ns / 100ps

module token_ring_range_lookup_unit_checker #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic clock,
   input  logic reset,
   trrl_req_if  req_mon,
   trrl_rsp_if  rsp_mon,
   output int   failures,
   output int   pending
);
   import trrl_pkg::*;

   typedef struct packed {
      logic [31:0]     found_address;
      trrl_status_type status;
   } range_result_type;

   // Start tokens are kept as order keys, so unsigned compares give token order.
   logic [63:0]      start_keys  [TABLE_ENTRIES];
   logic [31:0]      range_addrs [TABLE_ENTRIES];
   int               range_count;
   range_result_type awaited_results [$];

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      failures++;
   endtask

   function automatic range_result_type resolve_range(input logic [1:0] op,
                                                      input logic [63:0] token,
                                                      input logic [31:0] addr);
      range_result_type res;
      logic [63:0]      key;
      bit               matched;
      bit               have_below;
      int               below_idx;
      int               max_idx;
      res.found_address = '0;
      res.status        = ST_OK;
      key               = token ^ KEY_FLIP;
      matched           = 1'b0;
      have_below        = 1'b0;
      below_idx         = 0;
      max_idx           = 0;
      case (op)
         OP_INSERT: begin
            for (int i = 0; i < range_count; i++) begin
               if (!matched && start_keys[i] == key) begin
                  range_addrs[i] = addr;
                  matched        = 1'b1;
               end
            end
            if (!matched) begin
               if (range_count >= TABLE_ENTRIES) begin
                  res.status = ST_FULL;
               end else begin
                  start_keys[range_count]  = key;
                  range_addrs[range_count] = addr;
                  range_count++;
               end
            end
         end
         OP_LOOKUP: begin
            if (range_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               for (int i = 0; i < range_count; i++) begin
                  if (start_keys[i] > start_keys[max_idx]) begin
                     max_idx = i;
                  end
                  if (start_keys[i] <= key &&
                      (!have_below || start_keys[i] > start_keys[below_idx])) begin
                     below_idx  = i;
                     have_below = 1'b1;
                  end
               end
               // With no start at or below the token the lookup wraps to the top.
               res.found_address = range_addrs[have_below ? below_idx : max_idx];
            end
         end
         OP_CLEAR: begin
            range_count = 0;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      range_result_type want;
      if (reset) begin
         range_count = 0;
         awaited_results.delete();
         failures = 0;
         pending  = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("result with no item waiting: address %h status %0d",
                                         rsp_mon.found_address, rsp_mon.status));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_mon.found_address !== want.found_address) begin
                  report_mismatch($sformatf("found_address %h, expected %h",
                                            rsp_mon.found_address, want.found_address));
               end
               if (rsp_mon.status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_mon.status, want.status));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            want = resolve_range(req_mon.operation, req_mon.token, req_mon.node_address);
            awaited_results = {awaited_results, want};
         end
         pending = awaited_results.size();
      end
   end

endmodule

FILE: tb/token_ring_range_lookup_unit_test.sv
// Top of the token ring range lookup testbench: clock, reset, request
// stimulus with bursts and gaps, response stalls and the final verdict.
// Depends on trrl_pkg, trrl_chan_if, the block and its checker.
`timescale 1ns / 100ps

module token_ring_range_lookup_unit_test;
   import trrl_pkg::*;

   localparam int          TABLE_ENTRIES = 64;
   localparam int          ITEM_TARGET   = 1000;
   localparam logic [1:0]  OP_UNUSED     = 2'd3;
   localparam logic [63:0] TOKEN_MIN     = 64'h8000_0000_0000_0000;
   localparam logic [63:0] TOKEN_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] TOKEN_NEG_ONE = 64'hFFFF_FFFF_FFFF_FFFF;

   logic clock;
   logic reset;
   int   failure_count;
   int   pending_results;

   trrl_req_if req_chan ();
   trrl_rsp_if rsp_chan ();

   token_ring_range_lookup_unit #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   token_ring_range_lookup_unit_checker #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) i_checker (
      .clock   (clock),
      .reset   (reset),
      .req_mon (req_chan),
      .rsp_mon (rsp_chan),
      .failures(failure_count),
      .pending (pending_results)
   );

   logic [63:0] token_pool [$];
   int          items_sent  = 0;
   int          burst_left  = 0;
   bit          drain_next  = 1'b0;
   int          stall_left  = 0;
   int          ready_pct   = 100;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // The receiver moves between always ready, choppy and fully stalled stretches.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left == 0) begin
            stall_left = $urandom_range(10, 200);
            case ($urandom_range(0, 4))
               0, 1: ready_pct = 100;
               2: ready_pct = 50;
               3: ready_pct = 15;
               default: begin
                  ready_pct  = 0;
                  stall_left = $urandom_range(5, 120);
               end
            endcase
         end
         stall_left--;
         rsp_chan.ready <= ($urandom_range(0, 99) < ready_pct);
      end
   end

   function automatic logic [63:0] pick_token();
      logic [63:0] base;
      if (token_pool.size() == 0) begin
         return {$urandom, $urandom};
      end
      base = token_pool[$urandom_range(0, token_pool.size() - 1)];
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 5))
               0: return TOKEN_MIN;
               1: return TOKEN_MAX;
               2: return 64'd0;
               3: return TOKEN_NEG_ONE;
               4: return TOKEN_MIN + 64'd1;
               default: return TOKEN_MAX - 64'd1;
            endcase
         end
         1, 2, 3: return {$urandom, $urandom};
         4, 5, 6: return base;
         7: return base + 64'($urandom_range(1, 3));
         8: return base - 64'($urandom_range(1, 3));
         default: return 64'($signed($urandom_range(0, 31)) - 16);
      endcase
   endfunction

   function automatic logic [31:0] pick_address();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic offer_item(input logic [1:0] op, input logic [63:0] token,
                             input logic [31:0] addr);
      int gap;
      gap = 0;
      if (drain_next) begin
         drain_next = 1'b0;
         req_chan.valid <= 1'b0;
         wait (pending_results == 0);
         @(negedge clock);
      end else if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         case ($urandom_range(0, 3))
            0: gap = 0;
            1, 2: gap = $urandom_range(1, 4);
            default: gap = $urandom_range(5, 90);
         endcase
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_chan.valid        <= 1'b1;
      req_chan.operation    <= op;
      req_chan.token        <= token;
      req_chan.node_address <= addr;
      if (op == OP_INSERT) begin
         if (token_pool.size() < 200) begin
            token_pool = {token_pool, token};
         end else begin
            token_pool[$urandom_range(0, 199)] = token;
         end
      end
      if (op != OP_UNUSED) begin
         items_sent++;
      end
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic run_episode(input int length, input int insert_pct, input int fresh_pct,
                              input bit start_clear);
      int          pick;
      logic [63:0] token;
      if (start_clear) begin
         offer_item(OP_CLEAR, {$urandom, $urandom}, $urandom);
      end
      for (int n = 0; n < length; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < insert_pct) begin
            if ($urandom_range(0, 99) < fresh_pct) begin
               token = {$urandom, $urandom};
            end else begin
               token = pick_token();
            end
            offer_item(OP_INSERT, token, pick_address());
         end else if (pick < 97) begin
            offer_item(OP_LOOKUP, pick_token(), $urandom);
         end else if (pick < 99) begin
            offer_item(OP_CLEAR, pick_token(), $urandom);
         end else begin
            offer_item(OP_UNUSED, {$urandom, $urandom}, $urandom);
         end
      end
   endtask

   initial begin
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.operation    = OP_INSERT;
      req_chan.token        = '0;
      req_chan.node_address = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Directed part: extremes, repeats, wrap around and the empty table.
      offer_item(OP_LOOKUP, 64'd0, 32'h1234_5678);
      offer_item(OP_UNUSED, {$urandom, $urandom}, $urandom);
      offer_item(OP_INSERT, TOKEN_MIN, 32'hFFFF_FFFF);
      offer_item(OP_INSERT, TOKEN_MAX, 32'h0000_0000);
      offer_item(OP_INSERT, 64'd0, 32'hA5A5_5A5A);
      offer_item(OP_LOOKUP, TOKEN_MIN, 32'h0);
      offer_item(OP_LOOKUP, TOKEN_MAX, 32'h0);
      offer_item(OP_LOOKUP, TOKEN_NEG_ONE, 32'h0);
      offer_item(OP_LOOKUP, 64'd0, 32'h0);
      offer_item(OP_LOOKUP, 64'd1, 32'h0);
      offer_item(OP_INSERT, 64'd0, 32'h1111_2222);
      offer_item(OP_LOOKUP, 64'd5, 32'hFFFF_FFFF);
      offer_item(OP_CLEAR, 64'd0, 32'h0);
      offer_item(OP_LOOKUP, TOKEN_MAX, 32'h0);
      offer_item(OP_INSERT, 64'd100, 32'h0000_0001);
      offer_item(OP_INSERT, 64'd200, 32'h0000_0002);
      offer_item(OP_LOOKUP, 64'd50, 32'h0);
      offer_item(OP_LOOKUP, TOKEN_MIN, 32'h0);
      offer_item(OP_LOOKUP, 64'd150, 32'h0);
      offer_item(OP_LOOKUP, 64'd200, 32'h0);
      offer_item(OP_INSERT, -64'sd5, 32'hFFFF_FFFF);
      offer_item(OP_LOOKUP, -64'sd6, 32'h0);
      offer_item(OP_UNUSED, 64'd100, 32'hDEAD_BEEF);
      offer_item(OP_LOOKUP, 64'd100, 32'h0);

      drain_next = 1'b1;
      // The first random episode offers far more inserts than the table can hold.
      run_episode(170, 70, 80, 1'b1);

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 3) == 0) begin
            drain_next = 1'b1;
         end
         case ($urandom_range(0, 3))
            0: run_episode($urandom_range(100, 180), 65, 80, 1'b1);
            1: run_episode($urandom_range(20, 80), 30, 20, 1'($urandom_range(0, 1)));
            2: run_episode($urandom_range(5, 20), 50, 50, 1'b1);
            default: run_episode($urandom_range(20, 100), 45, 40, 1'($urandom_range(0, 1)));
         endcase
      end

      req_chan.valid <= 1'b0;
      wait (pending_results == 0);
      repeat (2 * TABLE_ENTRIES + 10) @(posedge clock);
      if (failure_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
